### design/drf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the duplicate request filter
package drf_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 8;
    localparam int unsigned WINDOW_W        = 16;
    localparam int unsigned CODE_W          = 8;
    localparam int unsigned SEQ_W           = 8;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned SLOT_W          = 3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5000;
    localparam logic [CODE_W-1:0]   CODE_FREE    = 8'd0;

    typedef struct packed {
        logic              is_reply;
        logic [CODE_W-1:0] cmd_code;
        logic [SEQ_W-1:0]  seq_num;
        logic [TIME_W-1:0] now_ms;
    } drf_req_t;

    typedef struct packed {
        logic              is_duplicate;
        logic              recorded;
        logic [SLOT_W-1:0] slot_used;
    } drf_rsp_t;

endpackage

### design/duplicate_request_filter.sv
`timescale 1ns / 1ps
// top level: time-window duplicate request filter with a small entry table
//
// usage
//   req channel carries one message header per request (reply flag, code,
//   sequence number, current time in ms); rsp channel returns one result per
//   request: duplicate flag, recorded flag and the table slot written
//   cfg_we/cfg_data load the 16-bit window in ms; the user must write it only
//   while the block is idle, as the block itself does not enforce it
//   a request is captured in an input register, compared against all table
//   entries in parallel and its result registered; one request per cycle is
//   sustained while rsp_stall is low, since the table update of one request is
//   visible to the next request in the following cycle
// reset
//   rst_n clears the table (all entries free) and sets the window to 5000 ms
// stall
//   a stalled result holds in the output register; the input register keeps
//   taking requests until it is full too, then req_stall goes high
module duplicate_request_filter #(
    parameter int unsigned TABLE_DEPTH = drf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  drf_pkg::drf_req_t               req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output drf_pkg::drf_rsp_t               rsp_data,
    input  logic                            cfg_we,
    input  logic [drf_pkg::WINDOW_W-1:0]    cfg_data
);
    import drf_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [WINDOW_W-1:0] window_reg;

    logic                in_valid_reg;
    drf_req_t            in_reg;
    logic                out_valid_reg;
    drf_rsp_t            out_reg;

    logic [CODE_W-1:0]   code_reg [TABLE_DEPTH];
    logic [SEQ_W-1:0]    seq_reg  [TABLE_DEPTH];
    logic [TIME_W-1:0]   time_reg [TABLE_DEPTH];

    logic                out_load;
    logic                in_load;
    logic                under;
    logic [TIME_W-1:0]   start;
    logic [TABLE_DEPTH-1:0] fresh;
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] avail;
    logic [TABLE_DEPTH-1:0] sel;
    logic [IDX_W-1:0]    sel_idx;
    logic                dup;
    logic                do_write;
    drf_rsp_t            out_next;

    // output register frees up when empty or being taken
    assign out_load  = !out_valid_reg || !rsp_stall;
    assign req_stall = in_valid_reg && !out_load;
    assign in_load   = req_valid && !req_stall;

    assign under = in_reg.now_ms < TIME_W'(window_reg);
    assign start = in_reg.now_ms - TIME_W'(window_reg);

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            fresh[i] = !under && (time_reg[i] > start);
            hit[i]   = fresh[i] && (code_reg[i] == in_reg.cmd_code)
                       && (seq_reg[i] == in_reg.seq_num);
            avail[i] = (code_reg[i] == CODE_FREE) || !fresh[i];
        end
    end

    assign dup = |hit;
    // lowest available entry as a one-hot vector
    assign sel = avail & (~avail + TABLE_DEPTH'(1));

    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sel[i])
            begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    assign do_write = in_valid_reg && out_load && !in_reg.is_reply && !dup && (|avail);

    always_comb
    begin
        out_next = '0;
        if (!in_reg.is_reply)
        begin
            if (dup)
            begin
                out_next.is_duplicate = 1'b1;
            end
            else if (|avail)
            begin
                out_next.recorded  = 1'b1;
                out_next.slot_used = SLOT_W'({{SLOT_W{1'b0}}, sel_idx});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= req_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                code_reg[i] <= CODE_FREE;
                seq_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end
        else if (do_write)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (sel[i])
                begin
                    code_reg[i] <= in_reg.cmd_code;
                    seq_reg[i]  <= in_reg.seq_num;
                    time_reg[i] <= in_reg.now_ms;
                end
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

### design/drf_checker.sv
`timescale 1ns / 1ps
// port-level checker for the duplicate request filter, bound to the top level
module drf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input drf_pkg::drf_rsp_t               rsp_data
);

    // a request is either dropped or recorded, never both
    a_dup_not_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.is_duplicate && rsp_data.recorded))
        else $error("duplicate result also marked recorded");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.recorded) |-> (rsp_data.slot_used == '0))
        else $error("slot reported for unrecorded request");

    // input only backs up when the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled with output free");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed");

endmodule

bind duplicate_request_filter drf_checker u_drf_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// testbench for the duplicate request filter: directed, window, hold-off and random tests
module tb_top;
    import drf_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    drf_req_t            req_data = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    drf_rsp_t            rsp_data;
    logic                cfg_we = 1'b0;
    logic [WINDOW_W-1:0] cfg_data = '0;

    // shadow copy of the filter table and window
    logic [CODE_W-1:0]   tbl_code [DEPTH];
    logic [SEQ_W-1:0]    tbl_seq  [DEPTH];
    logic [TIME_W-1:0]   tbl_time [DEPTH];
    logic [WINDOW_W-1:0] model_window = WINDOW_RESET;

    drf_rsp_t            expected_verdicts [$];
    int                  mismatch_count = 0;
    bit                  idle_on = 1'b1;
    int                  rsp_hold_left = 0;
    int                  stall_left = 0;
    logic [TIME_W-1:0]   time_base = '0;

    duplicate_request_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // runs one request through the shadow table and returns its verdict
    function automatic drf_rsp_t filter_predict(input drf_req_t item);
        drf_rsp_t          verdict;
        logic              under;
        logic [TIME_W-1:0] cutoff;
        logic              hit;
        logic              done;
        verdict = '0;
        if (!item.is_reply)
        begin
            under  = item.now_ms < TIME_W'(model_window);
            cutoff = under ? '0 : item.now_ms - TIME_W'(model_window);
            hit    = 1'b0;
            done   = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_code[i] == item.cmd_code && tbl_seq[i] == item.seq_num &&
                    !under && tbl_time[i] > cutoff)
                    hit = 1'b1;
            end
            if (hit)
                verdict.is_duplicate = 1'b1;
            else
            begin
                // first free or stale entry takes the request
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!done && (tbl_code[i] == CODE_FREE || under || tbl_time[i] <= cutoff))
                    begin
                        tbl_code[i]       = item.cmd_code;
                        tbl_seq[i]        = item.seq_num;
                        tbl_time[i]       = item.now_ms;
                        verdict.recorded  = 1'b1;
                        verdict.slot_used = SLOT_W'(i);
                        done              = 1'b1;
                    end
                end
            end
        end
        return verdict;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            expected_verdicts.push_back(filter_predict(req_data));
    end

    always @(posedge clk)
    begin
        drf_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected result: is_duplicate %0d recorded %0d slot_used %0d",
                       rsp_data.is_duplicate, rsp_data.recorded, rsp_data.slot_used);
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (rsp_data.is_duplicate !== want.is_duplicate)
                begin
                    $error("is_duplicate: expected %0d, actual %0d",
                           want.is_duplicate, rsp_data.is_duplicate);
                    mismatch_count++;
                end
                if (rsp_data.recorded !== want.recorded)
                begin
                    $error("recorded: expected %0d, actual %0d",
                           want.recorded, rsp_data.recorded);
                    mismatch_count++;
                end
                if (rsp_data.slot_used !== want.slot_used)
                begin
                    $error("slot_used: expected %0d, actual %0d",
                           want.slot_used, rsp_data.slot_used);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver side: random stalls, plus a long hold when a test asks for one
    always @(negedge clk)
    begin
        int unsigned n;
        if (rsp_hold_left > 0)
        begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            n = idle_on ? pick_gap() : 0;
            if (n > 0)
            begin
                stall_left = n - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send_request(input drf_req_t item);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (expected_verdicts.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [WINDOW_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        model_window  = value;
    endtask

    function automatic drf_req_t next_random_request();
        drf_req_t item;
        item.is_reply = ($urandom_range(99) < 10);
        if ($urandom_range(99) < 5)
            item.cmd_code = CODE_FREE;
        else if ($urandom_range(99) < 20)
            item.cmd_code = CODE_W'($urandom);
        else
            item.cmd_code = CODE_W'($urandom_range(1, 6));
        item.seq_num = ($urandom_range(99) < 70) ? SEQ_W'($urandom_range(0, 3))
                                                 : SEQ_W'($urandom);
        time_base = time_base + TIME_W'($urandom_range(0, int'(model_window) / 3 + 2));
        if ($urandom_range(99) < 3)
            time_base = TIME_W'($urandom_range(0, int'(model_window)));
        item.now_ms = ($urandom_range(99) < 5) ? TIME_W'($urandom) : time_base;
        return item;
    endfunction

    task automatic test_directed();
        idle_on = 1'b1;
        send_request(drf_req_t'{1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
        send_request(drf_req_t'{1'b1, 8'h00, 8'h00, 32'd0});
        // now below the window: never a duplicate, always entry 0
        send_request(drf_req_t'{1'b0, 8'h11, 8'h01, 32'd0});
        send_request(drf_req_t'{1'b0, 8'h11, 8'h01, 32'd100});
        // code zero request leaves its entry free
        send_request(drf_req_t'{1'b0, CODE_FREE, 8'h55, 32'd6000});
        for (int i = 1; i <= DEPTH; i++)
            send_request(drf_req_t'{1'b0, CODE_W'(i), SEQ_W'(i), TIME_W'(10000 + i)});
        // table full of fresh entries
        send_request(drf_req_t'{1'b0, 8'h99, 8'h00, 32'd10010});
        send_request(drf_req_t'{1'b0, 8'h01, 8'h01, 32'd10020});
        send_request(drf_req_t'{1'b0, 8'h01, 8'h02, 32'd10020});
        // entry time equal to now minus window counts as stale
        send_request(drf_req_t'{1'b0, 8'h01, 8'h01, 32'd15001});
        send_request(drf_req_t'{1'b0, 8'h02, 8'h02, 32'd15002});
        send_request(drf_req_t'{1'b0, 8'h03, 8'h03, 32'd15002});
        send_request(drf_req_t'{1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
        send_request(drf_req_t'{1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
        send_request(drf_req_t'{1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
    endtask

    task automatic test_window_extremes();
        set_window('0);
        send_request(drf_req_t'{1'b0, 8'h05, 8'h05, 32'd100});
        send_request(drf_req_t'{1'b0, 8'h05, 8'h05, 32'd100});
        send_request(drf_req_t'{1'b0, 8'h05, 8'h05, 32'd99});
        set_window('1);
        send_request(drf_req_t'{1'b0, 8'h07, 8'h07, 32'd65534});
        send_request(drf_req_t'{1'b0, 8'h07, 8'h07, 32'd65535});
        send_request(drf_req_t'{1'b0, 8'h07, 8'h07, 32'd65536});
        send_request(drf_req_t'{1'b0, 8'h07, 8'h07, 32'd131071});
        set_window(16'd1);
        send_request(drf_req_t'{1'b0, 8'h09, 8'h09, 32'd7});
        send_request(drf_req_t'{1'b0, 8'h09, 8'h09, 32'd7});
        send_request(drf_req_t'{1'b0, 8'h09, 8'h09, 32'd8});
    endtask

    // receiver holds off while requests keep coming, so the input side stalls
    task automatic test_output_hold();
        set_window(16'd200);
        idle_on       = 1'b0;
        rsp_hold_left = 60;
        for (int i = 0; i < 20; i++)
            send_request(next_random_request());
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic [WINDOW_W-1:0] windows [6];
        int                  sent;
        drf_req_t            item;
        windows = '{WINDOW_RESET, 16'd0, 16'hFFFF, 16'd1,
                    WINDOW_W'($urandom), WINDOW_W'($urandom_range(2, 50))};
        foreach (windows[p])
        begin
            set_window(windows[p]);
            time_base = (p % 2 == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 20000));
            sent = 0;
            while (sent < 245)
            begin
                if (sent % 64 == 0)
                    idle_on = ($urandom_range(3) != 0);
                item = next_random_request();
                send_request(item);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_code[i] = '0;
            tbl_seq[i]  = '0;
            tbl_time[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_window_extremes();
        test_output_hold();
        test_random();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
